// File: rtl/tcgr_pkg.sv
// tcgr_pkg: shared types, codes and constants of the text cursor glyph renderer
`default_nettype none

package tcgr_pkg;

  // glyph store geometry
  localparam int unsigned GlyphCount   = 256;
  localparam int unsigned GlyphColumns = 5;

  // field widths
  localparam int unsigned CoordW = 12;
  localparam int unsigned FontAw = 11;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 12;

  // input item kinds
  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_SET  = 2'd1,
    KIND_HOME = 2'd2,
    KIND_FONT = 2'd3
  } tcgr_kind_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCREEN_WIDTH  = 3'd0,
    CFG_SCREEN_HEIGHT = 3'd1,
    CFG_TEXT_SCALE    = 3'd2,
    CFG_FORE_COLOR    = 3'd3,
    CFG_BACK_COLOR    = 3'd4,
    CFG_TAB_STEP      = 3'd5
  } tcgr_cfg_e;

  // control characters
  localparam logic [7:0] ChrTab = 8'h09;
  localparam logic [7:0] ChrLf  = 8'h0A;
  localparam logic [7:0] ChrCr  = 8'h0D;

  // configuration reset values
  localparam logic [11:0] RstScreenWidth  = 12'd640;
  localparam logic [11:0] RstScreenHeight = 12'd480;
  localparam logic [3:0]  RstTextScale    = 4'd1;
  localparam logic [3:0]  RstForeColor    = 4'd15;
  localparam logic [3:0]  RstBackColor    = 4'd0;
  localparam logic [7:0]  RstTabStep      = 8'd24;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CELLS = 2'd1,
    ST_FLUSH = 2'd2
  } tcgr_state_e;

  // input item
  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        char_code;
    logic [CoordW-1:0] set_x;
    logic [CoordW-1:0] set_y;
    logic [FontAw-1:0] font_addr;
    logic [7:0]        font_data;
  } tcgr_in_t;

  // result item
  typedef struct packed {
    logic              rect_valid;
    logic [CoordW-1:0] rect_x;
    logic [CoordW-1:0] rect_y;
    logic [5:0]        rect_w;
    logic [6:0]        rect_h;
    logic [3:0]        rect_color;
    logic [CoordW-1:0] cursor_col;
    logic [CoordW-1:0] cursor_row;
    logic              last;
  } tcgr_out_t;

endpackage

`default_nettype wire

// File: rtl/tcgr_stream_if.sv
// tcgr_stream_if: valid/ready channel carrying one payload struct
`default_nettype none

interface tcgr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/text_cursor_glyph_renderer_top.sv
// text_cursor_glyph_renderer_top: cursor keeper and glyph-to-rectangle sequencer
//
//   channel  dir  payload      transfer when
//   in_i     in   tcgr_in_t    in_i.valid && in_i.ready
//   out_o    out  tcgr_out_t   out_o.valid && out_o.ready
//   cfg      in   idx, data    cfg_we_i
//
// a drawn character passes from its transfer to the next input ready through
// an accept step, 48 cell steps (6 columns x 8 rows, one glyph bit a cycle unless
// the output register stalls) and a flush step; every other item takes accept and flush only
// one glyph column byte is read from the glyph memory per 8 cells
// reset clears cursor and control and loads the config reset values; the glyph memory is not cleared
// a stalled output register holds the sequencer; input is taken while the
// final result of the previous item still waits
`default_nettype none

module text_cursor_glyph_renderer_top #(
  parameter int unsigned GLYPH_COUNT = tcgr_pkg::GlyphCount
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [tcgr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [tcgr_pkg::CfgDataW-1:0]  cfg_data_i,
  tcgr_stream_if.sink                   in_i,
  tcgr_stream_if.source                 out_o
);

  localparam int unsigned StoreDepth = GLYPH_COUNT * tcgr_pkg::GlyphColumns;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam logic [2:0]  LastCol    = 3'(tcgr_pkg::GlyphColumns);
  localparam logic [2:0]  NumCols    = 3'(tcgr_pkg::GlyphColumns);

  // configuration registers
  logic [11:0] scr_w_q, scr_h_q;
  logic [3:0]  scale_q, fore_q, back_q;
  logic [7:0]  tab_q;

  // control state
  tcgr_pkg::tcgr_state_e state_q, state_d;
  logic [11:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [2:0]  col_q, col_d, row_q, row_d;
  logic        oob_q, oob_d;
  logic        out_v_q, out_v_d;

  // payload registers
  tcgr_pkg::tcgr_out_t pend_q, pend_d, out_q, out_d;
  logic [11:0] org_y_q, org_y_d, cell_x_q, cell_x_d, cell_y_q, cell_y_d;
  logic [10:0] base_q, base_d;

  // glyph memory
  logic [7:0]  glyph_mem [StoreDepth];
  logic [7:0]  rdata_q;
  logic        mem_we, rd_en;
  logic [10:0] rd_addr;

  tcgr_pkg::tcgr_in_t in_p;
  logic in_fire, adv, draw_start;

  assign in_p    = in_i.payload;
  assign in_i.ready = (state_q == tcgr_pkg::ST_IDLE);
  assign in_fire = in_i.valid && in_i.ready;
  assign adv     = !out_v_q || out_o.ready;

  assign out_o.valid   = out_v_q;
  assign out_o.payload = out_q;

  // effective scale and derived sizes
  logic [3:0]  s_eff;
  logic [5:0]  s6;
  logic [6:0]  s8, s12;
  assign s_eff = (scale_q == 4'd0) ? 4'd1 : ((scale_q > 4'd8) ? 4'd8 : scale_q);
  assign s6    = (6'(s_eff) << 2) + (6'(s_eff) << 1);
  assign s8    = 7'(s_eff) << 3;
  assign s12   = s8 + (7'(s_eff) << 2);

  // cursor arithmetic
  logic [12:0] row_sum, tab_sum;
  logic [11:0] row_next;
  logic        tab_fits, wraps, on_screen, is_ctrl;
  assign row_sum   = {1'b0, cur_y_q} + 13'(s8);
  assign row_next  = row_sum[12] ? 12'hFFF : row_sum[11:0];
  assign tab_sum   = {1'b0, cur_x_q} + 13'(tab_q);
  assign tab_fits  = tab_sum < {1'b0, scr_w_q};
  assign wraps     = ({2'b0, cur_x_q} + 14'(s12)) > {2'b0, scr_w_q};
  assign on_screen = (cur_x_q < scr_w_q) && (cur_y_q < scr_h_q);
  assign is_ctrl   = (in_p.char_code == tcgr_pkg::ChrLf) ||
                     (in_p.char_code == tcgr_pkg::ChrCr) ||
                     (in_p.char_code == tcgr_pkg::ChrTab);
  assign draw_start = (in_p.kind == tcgr_pkg::KIND_CHAR) && !is_ctrl && on_screen;

  // glyph bit of the current cell
  logic [7:0] line;
  logic       cell_bit, cell_emit;
  logic [2:0] col_nx;
  assign line      = ((col_q < NumCols) && !oob_q) ? rdata_q : 8'h00;
  assign cell_bit  = line[row_q];
  assign cell_emit = cell_bit || (back_q != fore_q);
  assign col_nx    = col_q + 3'd1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tcgr_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = draw_start ? tcgr_pkg::ST_CELLS : tcgr_pkg::ST_FLUSH;
        end
      end
      tcgr_pkg::ST_CELLS: begin
        if (adv && (row_q == 3'd7) && (col_q == LastCol)) begin
          state_d = tcgr_pkg::ST_FLUSH;
        end
      end
      tcgr_pkg::ST_FLUSH: begin
        if (adv) begin
          state_d = tcgr_pkg::ST_IDLE;
        end
      end
      default: state_d = tcgr_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    col_d    = col_q;
    row_d    = row_q;
    oob_d    = oob_q;
    pend_d   = pend_q;
    org_y_d  = org_y_q;
    cell_x_d = cell_x_q;
    cell_y_d = cell_y_q;
    base_d   = base_q;
    out_d    = out_q;
    out_v_d  = out_v_q;
    mem_we   = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = base_q + 11'(col_nx);

    if (out_o.ready) begin
      out_v_d = 1'b0;
    end

    case (state_q)
      tcgr_pkg::ST_IDLE: begin
        if (in_fire) begin
          // item without a rectangle unless overwritten below
          pend_d = '0;
          case (in_p.kind)
            tcgr_pkg::KIND_SET: begin
              cur_x_d = in_p.set_x;
              cur_y_d = in_p.set_y;
            end
            tcgr_pkg::KIND_HOME: begin
              cur_x_d = '0;
              cur_y_d = '0;
            end
            tcgr_pkg::KIND_FONT: begin
              mem_we = {1'b0, in_p.font_addr} < 12'(StoreDepth);
            end
            default: begin
              case (in_p.char_code)
                tcgr_pkg::ChrLf: begin
                  cur_y_d = row_next;
                  cur_x_d = '0;
                end
                tcgr_pkg::ChrCr: begin
                end
                tcgr_pkg::ChrTab: begin
                  if (tab_fits) begin
                    cur_x_d = tab_sum[11:0];
                  end
                end
                default: begin
                  // printable: advance with wrap
                  if (wraps) begin
                    cur_y_d = row_next;
                    cur_x_d = '0;
                  end else begin
                    cur_x_d = cur_x_q + 12'(s6);
                  end
                end
              endcase
            end
          endcase

          // set up the cell walk and fetch column 0
          base_d   = (11'(in_p.char_code) << 2) + 11'(in_p.char_code);
          oob_d    = {1'b0, in_p.char_code} >= 9'(GLYPH_COUNT);
          col_d    = '0;
          row_d    = '0;
          org_y_d  = cur_y_q;
          cell_x_d = cur_x_q;
          cell_y_d = cur_y_q;
          rd_addr  = (11'(in_p.char_code) << 2) + 11'(in_p.char_code);
          rd_en    = draw_start && !({1'b0, in_p.char_code} >= 9'(GLYPH_COUNT));
          if (draw_start) begin
            pend_d.rect_valid = 1'b1;
            pend_d.rect_x     = cur_x_q;
            pend_d.rect_y     = cur_y_q;
            pend_d.rect_w     = s6;
            pend_d.rect_h     = s8;
            pend_d.rect_color = 4'd0;
          end
        end
      end

      tcgr_pkg::ST_CELLS: begin
        if (adv) begin
          // pending result goes out, this cell becomes pending
          if (cell_emit) begin
            out_d            = pend_q;
            out_d.cursor_col = cur_x_q;
            out_d.cursor_row = cur_y_q;
            out_d.last       = 1'b0;
            out_v_d          = 1'b1;
            pend_d.rect_valid = 1'b1;
            pend_d.rect_x     = cell_x_q;
            pend_d.rect_y     = cell_y_q;
            pend_d.rect_w     = 6'(s_eff);
            pend_d.rect_h     = 7'(s_eff);
            pend_d.rect_color = cell_bit ? fore_q : back_q;
          end
          // step to the next cell
          if (row_q == 3'd7) begin
            row_d    = '0;
            col_d    = col_nx;
            cell_y_d = org_y_q;
            cell_x_d = cell_x_q + 12'(s_eff);
            rd_en    = (col_nx < NumCols) && !oob_q;
          end else begin
            row_d    = row_q + 3'd1;
            cell_y_d = cell_y_q + 12'(s_eff);
          end
        end
      end

      tcgr_pkg::ST_FLUSH: begin
        if (adv) begin
          out_d            = pend_q;
          out_d.cursor_col = cur_x_q;
          out_d.cursor_row = cur_y_q;
          out_d.last       = 1'b1;
          out_v_d          = 1'b1;
        end
      end

      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcgr_pkg::ST_IDLE;
      cur_x_q <= '0;
      cur_y_q <= '0;
      col_q   <= '0;
      row_q   <= '0;
      oob_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      col_q   <= col_d;
      row_q   <= row_d;
      oob_q   <= oob_d;
      out_v_q <= out_v_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= tcgr_pkg::RstScreenWidth;
      scr_h_q <= tcgr_pkg::RstScreenHeight;
      scale_q <= tcgr_pkg::RstTextScale;
      fore_q  <= tcgr_pkg::RstForeColor;
      back_q  <= tcgr_pkg::RstBackColor;
      tab_q   <= tcgr_pkg::RstTabStep;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tcgr_pkg::CFG_SCREEN_WIDTH:  scr_w_q <= cfg_data_i;
        tcgr_pkg::CFG_SCREEN_HEIGHT: scr_h_q <= cfg_data_i;
        tcgr_pkg::CFG_TEXT_SCALE:    scale_q <= cfg_data_i[3:0];
        tcgr_pkg::CFG_FORE_COLOR:    fore_q  <= cfg_data_i[3:0];
        tcgr_pkg::CFG_BACK_COLOR:    back_q  <= cfg_data_i[3:0];
        tcgr_pkg::CFG_TAB_STEP:      tab_q   <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_q   <= pend_d;
    out_q    <= out_d;
    org_y_q  <= org_y_d;
    cell_x_q <= cell_x_d;
    cell_y_q <= cell_y_d;
    base_q   <= base_d;
  end

  // glyph memory write port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      glyph_mem[in_p.font_addr[AddrW-1:0]] <= in_p.font_data;
    end
  end

  // glyph memory read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= glyph_mem[rd_addr[AddrW-1:0]];
    end
  end

endmodule

`default_nettype wire
